/* sv/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants shared by the parent-pointer tree table modules.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int VAL_W    = 8;

    localparam logic signed [IDX_W:0] IDX_NONE = -(IDX_W+1)'(1);

    typedef enum logic [1:0] {
        ACT_ROOT   = 2'd0,
        ACT_CHILD  = 2'd1,
        ACT_RSIB   = 2'd2,
        ACT_LCHILD = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ROOT_EXISTS = 2'd1,
        ST_FULL        = 2'd2,
        ST_NOT_FOUND   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_FWAIT,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             link_valid;
        logic [IDX_W-1:0] link_idx;
    } t_entry;

    typedef struct packed {
        t_action          mode;
        logic [VAL_W-1:0] pval;
        logic             ref_valid;
        logic [IDX_W-1:0] ref_idx;
        logic [IDX_W-1:0] pos;
    } t_match_req;

endpackage

/* sv/ppt_ram.sv */
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/ppt_match.sv */
// ----------------------------------------------------------------------------
// ppt_match
// Shared compare unit: tests one table entry against the key of the action.
// ----------------------------------------------------------------------------
module ppt_match import ppt_pkg::*; (
    input  t_match_req i_req,
    input  t_entry     i_entry,
    output logic       o_hit
);

    always_comb begin
        case (i_req.mode)
            ACT_CHILD: begin
                o_hit = (i_entry.value == i_req.pval);
            end
            ACT_RSIB: begin
                // root-level nodes are siblings of one another
                o_hit = (i_entry.link_valid == i_req.ref_valid) &&
                        (!i_entry.link_valid || (i_entry.link_idx == i_req.ref_idx));
            end
            ACT_LCHILD: begin
                o_hit = i_entry.link_valid && (i_entry.link_idx == i_req.pos);
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule

/* sv/parent_pointer_tree_table.sv */
// Root insert: write state, then result strobe; a rejected word skips the write state.
// Child insert and queries read one table entry per cycle through the single
// RAM read port; a new word is taken the cycle after the result strobe.
// The result strobe cannot be held off by the receiver.
// Synchronous active-low reset empties the table; stored entries are not cleared.
// ----------------------------------------------------------------------------
// parent_pointer_tree_table
// Tree table in parent-pointer form with root/child insert and sibling/child
// queries, run by a small sequencer over one RAM and one compare unit.
// ----------------------------------------------------------------------------
module parent_pointer_tree_table import ppt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_action,
    input  logic [VAL_W-1:0]         i_node_value,
    input  logic [VAL_W-1:0]         i_parent_value,
    input  logic [IDX_W-1:0]         i_position,
    output logic                     o_valid,
    output logic signed [IDX_W:0]    o_result_index,
    output logic [VAL_W-1:0]         o_result_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_count_after,
    output logic                     o_tree_empty
);

    t_state               r_state, n_state;
    t_action              r_act, n_act;
    logic [VAL_W-1:0]     r_nval, n_nval;
    logic [VAL_W-1:0]     r_pval, n_pval;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_ref_v, n_ref_v;
    logic [IDX_W-1:0]     r_ref_idx, n_ref_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_par, n_par;
    logic signed [IDX_W:0] r_res_idx, n_res_idx;
    logic [VAL_W-1:0]     r_res_val, n_res_val;
    t_status              r_status, n_status;

    t_action              w_in_act;
    logic                 w_full;
    logic                 w_pos_ok;
    logic                 w_issue;
    logic                 w_hit;
    logic                 w_exhaust;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_entry               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry               rd_entry;

    t_match_req           m_req;
    logic                 m_hit;

    assign w_in_act  = t_action'(i_action);
    assign w_full    = (r_count >= CNT_W'(CAPACITY));
    assign w_pos_ok  = ({1'b0, i_position} < r_count);
    assign w_issue   = (r_state == S_SCAN) && (r_addr < r_count);
    assign w_hit     = r_rd_vld && m_hit;
    assign w_exhaust = !r_rd_vld && (r_addr >= r_count);
    assign rd_entry  = t_entry'(ram_rdata);

    assign m_req.mode      = r_act;
    assign m_req.pval      = r_pval;
    assign m_req.ref_valid = r_ref_v;
    assign m_req.ref_idx   = r_ref_idx;
    assign m_req.pos       = r_pos;

    ppt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ppt_match u_match (
        .i_req   (m_req),
        .i_entry (rd_entry),
        .o_hit   (m_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (w_in_act)
                        ACT_ROOT:  n_state = (r_count != '0) ? S_DONE : S_WRITE;
                        ACT_CHILD: n_state = w_full ? S_DONE : S_SCAN;
                        ACT_RSIB:  n_state = w_pos_ok ? S_FETCH : S_DONE;
                        default:   n_state = S_SCAN;
                    endcase
                end
            end
            S_FETCH: n_state = S_FWAIT;
            S_FWAIT: n_state = S_SCAN;
            S_SCAN: begin
                if (w_hit || w_exhaust) begin
                    n_state = (r_act == ACT_CHILD) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_act     = r_act;
        n_nval    = r_nval;
        n_pval    = r_pval;
        n_pos     = r_pos;
        n_count   = r_count;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_addr[IDX_W-1:0];
        n_ref_v   = r_ref_v;
        n_ref_idx = r_ref_idx;
        n_found   = r_found;
        n_par     = r_par;
        n_res_idx = r_res_idx;
        n_res_val = r_res_val;
        n_status  = r_status;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act     = w_in_act;
                    n_nval    = i_node_value;
                    n_pval    = i_parent_value;
                    n_pos     = i_position;
                    n_found   = 1'b0;
                    n_par     = '0;
                    n_res_idx = IDX_NONE;
                    n_res_val = '0;
                    n_status  = ST_NOT_FOUND;
                    n_addr    = (w_in_act == ACT_CHILD) ? '0
                                                        : ({1'b0, i_position} + CNT_W'(1));
                    if (w_in_act == ACT_ROOT) begin
                        n_status = ST_ROOT_EXISTS;
                    end else if (w_in_act == ACT_CHILD) begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_FWAIT: begin
                n_ref_v   = rd_entry.link_valid;
                n_ref_idx = rd_entry.link_idx;
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + CNT_W'(1);
                end
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_par     = r_rd_idx;
                    n_res_idx = $signed({1'b0, r_rd_idx});
                    n_res_val = rd_entry.value;
                    n_status  = ST_OK;
                end
            end
            S_WRITE: begin
                n_res_idx = $signed({1'b0, r_count[IDX_W-1:0]});
                n_res_val = r_nval;
                n_status  = ST_OK;
                n_count   = r_count + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // control outputs
    always_comb begin
        busy      = (r_state != S_IDLE);
        o_valid   = (r_state == S_DONE);
        ram_we    = (r_state == S_WRITE);
        ram_waddr = r_count[IDX_W-1:0];
        ram_wdata.value      = r_nval;
        ram_wdata.link_valid = r_found;
        ram_wdata.link_idx   = r_par;
        ram_raddr = (r_state == S_FETCH) ? r_pos : r_addr[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_nval    <= n_nval;
        r_pval    <= n_pval;
        r_pos     <= n_pos;
        r_addr    <= n_addr;
        r_rd_idx  <= n_rd_idx;
        r_ref_v   <= n_ref_v;
        r_ref_idx <= n_ref_idx;
        r_found   <= n_found;
        r_par     <= n_par;
        r_res_idx <= n_res_idx;
        r_res_val <= n_res_val;
        r_status  <= n_status;
    end

    assign o_result_index = r_res_idx;
    assign o_result_value = r_res_val;
    assign o_status       = r_status;
    assign o_count_after  = r_count;
    assign o_tree_empty   = (r_count == '0);

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("node count beyond capacity");

    // node count only moves on a table write
    a_count_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == S_WRITE))
        else $error("node count changed outside a write");

    a_ok_has_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |-> (o_result_index != IDX_NONE))
        else $error("ok result without an index");

    a_fail_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
            ((o_result_value == '0) && (o_result_index == IDX_NONE)))
        else $error("failed result carries data");

endmodule

/* dv/tb_parent_pointer_tree_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parent_pointer_tree_table
// Self-checking bench for the parent-pointer tree table. A directed table
// builds a small tree and asks the corner questions. A long random run then
// fills the table and queries it. Each result word is compared with the
// listed outcome of a typed row, else with a behavioural table model.
// ----------------------------------------------------------------------------
module tb_parent_pointer_tree_table;
    import ppt_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int N_RAND     = 2000;
    localparam int TIMEOUT_NS = 10_000_000;

    typedef struct packed {
        t_action          act;
        logic [VAL_W-1:0] nval;
        logic [VAL_W-1:0] pval;
        logic [IDX_W-1:0] pos;
    } t_word;

    typedef struct packed {
        logic signed [IDX_W:0] idx;
        logic [VAL_W-1:0]      val;
        t_status               st;
        logic [CNT_W-1:0]      cnt;
        logic                  empty;
    } t_outcome;

    typedef struct packed {
        t_word    w;
        logic     typed;
        t_outcome want;
    } t_row;

    localparam t_outcome NO_EXP = '0;
    localparam int       N_DIR  = 19;

    // builds root ff with children 00 and 80, 55 under 80, aa with no parent,
    // 7f under 00, then asks about siblings and children
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{'{ACT_RSIB,   8'h00, 8'h00, 5'd0 }, 1'b1, '{IDX_NONE, 8'h00, ST_NOT_FOUND, 6'd0, 1'b1}},
        '{'{ACT_LCHILD, 8'hff, 8'hff, 5'd31}, 1'b1, '{IDX_NONE, 8'h00, ST_NOT_FOUND, 6'd0, 1'b1}},
        '{'{ACT_ROOT,   8'hff, 8'h00, 5'd0 }, 1'b1, '{6'd0,     8'hff, ST_OK,        6'd1, 1'b0}},
        '{'{ACT_ROOT,   8'h00, 8'h00, 5'd0 }, 1'b1, '{IDX_NONE, 8'h00, ST_ROOT_EXISTS, 6'd1, 1'b0}},
        '{'{ACT_CHILD,  8'h00, 8'hff, 5'd0 }, 1'b1, '{6'd1,     8'h00, ST_OK,        6'd2, 1'b0}},
        '{'{ACT_CHILD,  8'h80, 8'hff, 5'd0 }, 1'b1, '{6'd2,     8'h80, ST_OK,        6'd3, 1'b0}},
        '{'{ACT_CHILD,  8'h55, 8'h80, 5'd0 }, 1'b1, '{6'd3,     8'h55, ST_OK,        6'd4, 1'b0}},
        '{'{ACT_CHILD,  8'haa, 8'h13, 5'd0 }, 1'b1, '{6'd4,     8'haa, ST_OK,        6'd5, 1'b0}},
        '{'{ACT_CHILD,  8'h7f, 8'h00, 5'd0 }, 1'b1, '{6'd5,     8'h7f, ST_OK,        6'd6, 1'b0}},
        '{'{ACT_RSIB,   8'h00, 8'h00, 5'd0 }, 1'b0, NO_EXP},
        '{'{ACT_RSIB,   8'h00, 8'h00, 5'd1 }, 1'b0, NO_EXP},
        '{'{ACT_LCHILD, 8'h00, 8'h00, 5'd0 }, 1'b0, NO_EXP},
        '{'{ACT_LCHILD, 8'h00, 8'h00, 5'd2 }, 1'b0, NO_EXP},
        '{'{ACT_LCHILD, 8'h00, 8'h00, 5'd5 }, 1'b0, NO_EXP},
        '{'{ACT_RSIB,   8'h00, 8'h00, 5'd31}, 1'b1, '{IDX_NONE, 8'h00, ST_NOT_FOUND, 6'd6, 1'b0}},
        '{'{ACT_LCHILD, 8'h00, 8'h00, 5'd31}, 1'b1, '{IDX_NONE, 8'h00, ST_NOT_FOUND, 6'd6, 1'b0}},
        '{'{ACT_RSIB,   8'h00, 8'h00, 5'd5 }, 1'b0, NO_EXP},
        '{'{ACT_CHILD,  8'hff, 8'h55, 5'd0 }, 1'b0, NO_EXP},
        '{'{ACT_LCHILD, 8'h00, 8'h00, 5'd3 }, 1'b0, NO_EXP}
    };

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [1:0]            i_action       = '0;
    logic [VAL_W-1:0]      i_node_value   = '0;
    logic [VAL_W-1:0]      i_parent_value = '0;
    logic [IDX_W-1:0]      i_position     = '0;
    logic                  busy;
    logic                  o_valid;
    logic signed [IDX_W:0] o_result_index;
    logic [VAL_W-1:0]      o_result_value;
    logic [1:0]            o_status;
    logic [CNT_W-1:0]      o_count_after;
    logic                  o_tree_empty;

    // model of the table
    logic [VAL_W-1:0] tree_vals [CAPACITY];
    bit               link_ok   [CAPACITY];
    int               link_to   [CAPACITY];
    int               tree_count = 0;

    t_outcome pending_outcomes [$];
    int       n_err      = 0;
    int       words_sent = 0;

    parent_pointer_tree_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_node_value   (i_node_value),
        .i_parent_value (i_parent_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .o_result_index (o_result_index),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_count_after  (o_count_after),
        .o_tree_empty   (o_tree_empty)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // applies one word to the table model and returns the result it gives
    function automatic t_outcome tree_step(t_word w);
        t_outcome r;
        bit       hit;
        int       par;
        r   = '{IDX_NONE, 8'h00, ST_NOT_FOUND, 6'd0, 1'b0};
        hit = 1'b0;
        par = 0;
        case (w.act)
            ACT_ROOT: begin
                if (tree_count != 0) begin
                    r.st = ST_ROOT_EXISTS;
                end else begin
                    tree_vals[0] = w.nval;
                    link_ok[0]   = 1'b0;
                    link_to[0]   = 0;
                    tree_count   = 1;
                    r.idx = '0;
                    r.val = w.nval;
                    r.st  = ST_OK;
                end
            end
            ACT_CHILD: begin
                if (tree_count >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    // first match wins; no match leaves the node unlinked
                    for (int i = 0; i < tree_count; i++) begin
                        if (!hit && tree_vals[i] == w.pval) begin
                            hit = 1'b1;
                            par = i;
                        end
                    end
                    tree_vals[tree_count] = w.nval;
                    link_ok[tree_count]   = hit;
                    link_to[tree_count]   = par;
                    r.idx = (IDX_W+1)'(tree_count);
                    r.val = w.nval;
                    r.st  = ST_OK;
                    tree_count++;
                end
            end
            ACT_RSIB: begin
                if (int'(w.pos) < tree_count) begin
                    for (int i = int'(w.pos) + 1; i < tree_count; i++) begin
                        // unlinked nodes count as siblings of the root
                        if (!hit && link_ok[i] == link_ok[w.pos] &&
                            (!link_ok[i] || link_to[i] == link_to[w.pos])) begin
                            hit   = 1'b1;
                            r.idx = (IDX_W+1)'(i);
                            r.val = tree_vals[i];
                            r.st  = ST_OK;
                        end
                    end
                end
            end
            ACT_LCHILD: begin
                for (int i = int'(w.pos) + 1; i < tree_count; i++) begin
                    if (!hit && link_ok[i] && link_to[i] == int'(w.pos)) begin
                        hit   = 1'b1;
                        r.idx = (IDX_W+1)'(i);
                        r.val = tree_vals[i];
                        r.st  = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
        r.cnt   = CNT_W'(tree_count);
        r.empty = (tree_count == 0);
        return r;
    endfunction

    // random mix of inserts, mostly under existing parents, and queries on the tree
    function automatic t_word random_word();
        t_word w;
        int    roll;
        bit    is_full;
        w.nval  = $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 7)) : VAL_W'($urandom);
        w.pval  = VAL_W'($urandom);
        w.pos   = IDX_W'($urandom);
        roll    = $urandom_range(0, 99);
        is_full = (tree_count >= CAPACITY);
        if (roll < (is_full ? 2 : 3)) begin
            w.act = ACT_ROOT;
        end else if (roll < (is_full ? 6 : 43)) begin
            w.act = ACT_CHILD;
            if (tree_count > 0 && $urandom_range(0, 99) < 80)
                w.pval = tree_vals[$urandom_range(0, tree_count - 1)];
        end else begin
            w.act = $urandom_range(0, 1) ? ACT_RSIB : ACT_LCHILD;
            if (tree_count > 0 && $urandom_range(0, 9) < 8)
                w.pos = IDX_W'($urandom_range(0, tree_count - 1));
        end
        return w;
    endfunction

    task automatic send_word(t_word w, logic typed, t_outcome want);
        t_outcome model_r;
        // random idle gaps before a word, except in a back-to-back stretch mid-run
        if ((words_sent < 900 || words_sent >= 1200) && $urandom_range(0, 99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= w.act;
        i_node_value   <= w.nval;
        i_parent_value <= w.pval;
        i_position     <= w.pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model_r = tree_step(w);
        pending_outcomes.push_back(typed ? want : model_r);
        words_sent++;
    endtask

    function automatic void check_field(string name, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with none outstanding");
                n_err++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("result_index", 32'($signed(want.idx)),
                            32'($signed(o_result_index)));
                check_field("result_value", 32'(want.val), 32'(o_result_value));
                check_field("status", 32'(want.st), 32'(o_status));
                check_field("count_after", 32'(want.cnt), 32'(o_count_after));
                check_field("tree_empty", 32'(want.empty), 32'(o_tree_empty));
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIR; k++)
            send_word(DIR_ROWS[k].w, DIR_ROWS[k].typed, DIR_ROWS[k].want);
        for (int k = 0; k < N_RAND; k++)
            send_word(random_word(), 1'b0, NO_EXP);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("** parent_pointer_tree_table: PASSED **");
        end else begin
            $display("** parent_pointer_tree_table: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** parent_pointer_tree_table: FAILED **");
        $finish;
    end

endmodule
